@@ rtl/hrlp_pkg.sv @@
// shared types and constants for the http request line parser
// no dependencies; used by the front, back and top level modules
package hrlp_pkg;

   // parse phases; the five prefix phases step through the text "HTTP/"
   typedef enum logic [3:0] {
      PH_METHOD  = 4'd0,
      PH_SP1     = 4'd1,
      PH_PATH    = 4'd2,
      PH_QUERY   = 4'd3,
      PH_FRAG    = 4'd4,
      PH_SP2     = 4'd5,
      PH_PREFIX0 = 4'd6,
      PH_PREFIX1 = 4'd7,
      PH_PREFIX2 = 4'd8,
      PH_PREFIX3 = 4'd9,
      PH_PREFIX4 = 4'd10,
      PH_MAJOR   = 4'd11,
      PH_MINOR   = 4'd12,
      PH_TAIL    = 4'd13
   } phase_type;

   // byte tags
   typedef enum logic [2:0] {
      TAG_METHOD  = 3'd0,
      TAG_SPACE   = 3'd1,
      TAG_PATH    = 3'd2,
      TAG_QUERY   = 3'd3,
      TAG_FRAG    = 3'd4,
      TAG_VERSION = 3'd5,
      TAG_IGNORED = 3'd6
   } tag_type;

   // per-byte record passed from the front part to the back part
   typedef struct packed {
      logic [7:0] line_byte;
      tag_type    tag;
      logic       eol;
      logic       pre_valid;
      logic       is_09;
      logic [3:0] code;
   } front_rec_type;

   // match result when no method name fits
   localparam logic [3:0] CODE_NONE = 4'd8;

   // method text limits
   localparam logic [3:0] LEN_STORE = 4'd7;
   localparam logic [3:0] LEN_SAT   = 4'd8;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // method names, first character in the low byte
   localparam logic [55:0] METHOD_NAMES [8] = '{
      56'h00000000544547,   // GET
      56'h534E4F4954504F,   // OPTIONS
      56'h00000044414548,   // HEAD
      56'h00000054534F50,   // POST
      56'h00000000545550,   // PUT
      56'h004554454C4544,   // DELETE
      56'h00004543415254,   // TRACE
      56'h5443454E4E4F43    // CONNECT
   };
   localparam logic [3:0] METHOD_LENS [8] = '{
      4'd3, 4'd7, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7
   };

   // lowest matching code wins; bytes past the length are always zero
   function automatic logic [3:0] match_method(input logic [55:0] text,
                                               input logic [3:0]  len);
      logic [3:0] code;
      code = CODE_NONE;
      for (int k = 7; k >= 0; k--) begin
         if (len == METHOD_LENS[k] && text == METHOD_NAMES[k]) begin
            code = 4'(k);
         end
      end
      return code;
   endfunction

   // characters of the version prefix "HTTP/"
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h48;
         3'd1:    ch = 8'h54;
         3'd2:    ch = 8'h54;
         3'd3:    ch = 8'h50;
         3'd4:    ch = 8'h2F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ rtl/hrlp_front.sv @@
// front part: per-byte parse state machine, tags each byte and gathers the verdict inputs
// depends on hrlp_pkg
module hrlp_front #(
   parameter int VERSION_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [7:0]                  line_byte,
   input  logic                        line_end,
   output hrlp_pkg::front_rec_type     rec,
   output logic [VERSION_BITS-1:0]     rec_major,
   output logic [VERSION_BITS-1:0]     rec_minor
);

   localparam int EXT_W = VERSION_BITS + 4;

   hrlp_pkg::phase_type phase_ff, phase_in, phase_upd, eff_phase;
   logic [55:0]             text_ff, text_in, text_upd;
   logic [3:0]              len_ff, len_in, len_upd;
   logic [VERSION_BITS-1:0] major_ff, major_in, major_upd, major_acc;
   logic [VERSION_BITS-1:0] minor_ff, minor_in, minor_upd, minor_acc;
   logic                    seen_ff, seen_in, seen_upd;
   logic                    failed_ff, failed_in, failed_upd;
   logic [EXT_W-1:0]        major_wide, minor_wide, vmax_wide;
   logic [7:0]              digit_diff;
   logic [2:0]              prefix_idx;
   logic [3:0]              code_now;
   logic                    is_space, is_digit, is_nul, is_end;
   hrlp_pkg::tag_type       tag;

   // byte classes
   assign is_nul     = (line_byte == hrlp_pkg::CH_NUL);
   assign is_space   = (line_byte == hrlp_pkg::CH_SPACE);
   assign is_digit   = (line_byte >= hrlp_pkg::CH_ZERO) && (line_byte <= hrlp_pkg::CH_NINE);
   assign is_end     = line_end || is_nul;
   assign digit_diff = line_byte - hrlp_pkg::CH_ZERO;
   assign code_now   = hrlp_pkg::match_method(text_ff, len_ff);
   assign prefix_idx = 3'(eff_phase - hrlp_pkg::PH_PREFIX0);

   // saturating decimal accumulation
   assign vmax_wide  = EXT_W'({VERSION_BITS{1'b1}});
   assign major_wide = EXT_W'(major_ff) * EXT_W'(10) + EXT_W'(digit_diff[3:0]);
   assign minor_wide = EXT_W'(minor_ff) * EXT_W'(10) + EXT_W'(digit_diff[3:0]);
   assign major_acc  = (major_wide > vmax_wide) ? {VERSION_BITS{1'b1}}
                                                : major_wide[VERSION_BITS-1:0];
   assign minor_acc  = (minor_wide > vmax_wide) ? {VERSION_BITS{1'b1}}
                                                : minor_wide[VERSION_BITS-1:0];

   // a non-space after a space run falls into the following phase
   always_comb begin
      eff_phase = phase_ff;
      if (phase_ff == hrlp_pkg::PH_SP1 && !is_space) begin
         eff_phase = hrlp_pkg::PH_PATH;
      end else if (phase_ff == hrlp_pkg::PH_SP2 && !is_space) begin
         eff_phase = hrlp_pkg::PH_PREFIX0;
      end
   end

   // next state: effect of this byte, then the end-of-line clear
   always_comb begin
      phase_upd  = phase_ff;
      text_upd   = text_ff;
      len_upd    = len_ff;
      major_upd  = major_ff;
      minor_upd  = minor_ff;
      seen_upd   = seen_ff;
      failed_upd = failed_ff;
      if (!is_nul && !failed_ff) begin
         // a processed non-space byte leaves a space run for good
         phase_upd = eff_phase;
         unique case (eff_phase)
            hrlp_pkg::PH_METHOD: begin
               if (is_space) begin
                  if (code_now == hrlp_pkg::CODE_NONE) begin
                     failed_upd = 1'b1;
                     phase_upd  = hrlp_pkg::PH_TAIL;
                  end else begin
                     phase_upd = hrlp_pkg::PH_SP1;
                  end
               end else begin
                  if (len_ff < hrlp_pkg::LEN_STORE) begin
                     text_upd[8*len_ff[2:0] +: 8] = line_byte;
                  end
                  if (len_ff < hrlp_pkg::LEN_SAT) begin
                     len_upd = len_ff + 4'd1;
                  end
               end
            end
            hrlp_pkg::PH_SP1: ;
            hrlp_pkg::PH_SP2: ;
            hrlp_pkg::PH_PATH: begin
               if (is_space) begin
                  phase_upd = hrlp_pkg::PH_SP2;
               end else if (line_byte == hrlp_pkg::CH_QUEST) begin
                  phase_upd = hrlp_pkg::PH_QUERY;
               end else if (line_byte == hrlp_pkg::CH_HASH) begin
                  phase_upd = hrlp_pkg::PH_FRAG;
               end
            end
            hrlp_pkg::PH_QUERY: begin
               if (is_space) begin
                  phase_upd = hrlp_pkg::PH_SP2;
               end else if (line_byte == hrlp_pkg::CH_HASH) begin
                  phase_upd = hrlp_pkg::PH_FRAG;
               end
            end
            hrlp_pkg::PH_FRAG: begin
               if (is_space) begin
                  phase_upd = hrlp_pkg::PH_SP2;
               end
            end
            hrlp_pkg::PH_PREFIX0, hrlp_pkg::PH_PREFIX1, hrlp_pkg::PH_PREFIX2,
            hrlp_pkg::PH_PREFIX3, hrlp_pkg::PH_PREFIX4: begin
               if (line_byte != hrlp_pkg::prefix_char(prefix_idx)) begin
                  failed_upd = 1'b1;
                  phase_upd  = hrlp_pkg::PH_TAIL;
               end else begin
                  phase_upd = hrlp_pkg::phase_type'(4'(eff_phase + 4'd1));
               end
            end
            hrlp_pkg::PH_MAJOR: begin
               if (is_digit) begin
                  major_upd = major_acc;
                  seen_upd  = 1'b1;
               end else if (line_byte == hrlp_pkg::CH_DOT && seen_ff) begin
                  seen_upd  = 1'b0;
                  phase_upd = hrlp_pkg::PH_MINOR;
               end else begin
                  failed_upd = 1'b1;
                  phase_upd  = hrlp_pkg::PH_TAIL;
               end
            end
            hrlp_pkg::PH_MINOR: begin
               if (is_digit) begin
                  minor_upd = minor_acc;
                  seen_upd  = 1'b1;
               end else if (seen_ff) begin
                  phase_upd = hrlp_pkg::PH_TAIL;
               end else begin
                  failed_upd = 1'b1;
                  phase_upd  = hrlp_pkg::PH_TAIL;
               end
            end
            default: ;
         endcase
      end
      phase_in  = phase_ff;
      text_in   = text_ff;
      len_in    = len_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      seen_in   = seen_ff;
      failed_in = failed_ff;
      if (take) begin
         if (is_end) begin
            phase_in  = hrlp_pkg::PH_METHOD;
            text_in   = '0;
            len_in    = '0;
            major_in  = '0;
            minor_in  = '0;
            seen_in   = 1'b0;
            failed_in = 1'b0;
         end else begin
            phase_in  = phase_upd;
            text_in   = text_upd;
            len_in    = len_upd;
            major_in  = major_upd;
            minor_in  = minor_upd;
            seen_in   = seen_upd;
            failed_in = failed_upd;
         end
      end
   end

   // outputs: byte tag
   always_comb begin
      tag = hrlp_pkg::TAG_IGNORED;
      if (!is_nul && !failed_ff) begin
         unique case (eff_phase)
            hrlp_pkg::PH_METHOD: begin
               tag = is_space ? hrlp_pkg::TAG_SPACE : hrlp_pkg::TAG_METHOD;
            end
            hrlp_pkg::PH_SP1, hrlp_pkg::PH_SP2: begin
               tag = hrlp_pkg::TAG_SPACE;
            end
            hrlp_pkg::PH_PATH: begin
               if (is_space) begin
                  tag = hrlp_pkg::TAG_SPACE;
               end else if (line_byte == hrlp_pkg::CH_QUEST) begin
                  tag = hrlp_pkg::TAG_QUERY;
               end else if (line_byte == hrlp_pkg::CH_HASH) begin
                  tag = hrlp_pkg::TAG_FRAG;
               end else begin
                  tag = hrlp_pkg::TAG_PATH;
               end
            end
            hrlp_pkg::PH_QUERY: begin
               if (is_space) begin
                  tag = hrlp_pkg::TAG_SPACE;
               end else if (line_byte == hrlp_pkg::CH_HASH) begin
                  tag = hrlp_pkg::TAG_FRAG;
               end else begin
                  tag = hrlp_pkg::TAG_QUERY;
               end
            end
            hrlp_pkg::PH_FRAG: begin
               tag = is_space ? hrlp_pkg::TAG_SPACE : hrlp_pkg::TAG_FRAG;
            end
            hrlp_pkg::PH_PREFIX0, hrlp_pkg::PH_PREFIX1, hrlp_pkg::PH_PREFIX2,
            hrlp_pkg::PH_PREFIX3, hrlp_pkg::PH_PREFIX4: begin
               tag = (line_byte == hrlp_pkg::prefix_char(prefix_idx))
                     ? hrlp_pkg::TAG_VERSION : hrlp_pkg::TAG_IGNORED;
            end
            hrlp_pkg::PH_MAJOR: begin
               tag = (is_digit || (line_byte == hrlp_pkg::CH_DOT && seen_ff))
                     ? hrlp_pkg::TAG_VERSION : hrlp_pkg::TAG_IGNORED;
            end
            hrlp_pkg::PH_MINOR: begin
               tag = is_digit ? hrlp_pkg::TAG_VERSION : hrlp_pkg::TAG_IGNORED;
            end
            default: tag = hrlp_pkg::TAG_IGNORED;
         endcase
      end
   end

   // outputs: record with the verdict inputs from the updated state
   always_comb begin
      rec.line_byte = line_byte;
      rec.tag       = tag;
      rec.eol       = is_end;
      rec.code      = code_now;
      rec.is_09     = (phase_upd == hrlp_pkg::PH_PATH) || (phase_upd == hrlp_pkg::PH_QUERY)
                   || (phase_upd == hrlp_pkg::PH_FRAG) || (phase_upd == hrlp_pkg::PH_SP2);
      rec.pre_valid = is_end && !failed_upd
                   && (rec.is_09 || (phase_upd == hrlp_pkg::PH_TAIL)
                       || (phase_upd == hrlp_pkg::PH_MINOR && seen_upd));
      rec_major     = major_upd;
      rec_minor     = minor_upd;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hrlp_pkg::PH_METHOD;
         text_ff   <= '0;
         len_ff    <= '0;
         major_ff  <= '0;
         minor_ff  <= '0;
         seen_ff   <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         text_ff   <= text_in;
         len_ff    <= len_in;
         major_ff  <= major_in;
         minor_ff  <= minor_in;
         seen_ff   <= seen_in;
         failed_ff <= failed_in;
      end
   end

endmodule

@@ rtl/hrlp_queue.sv @@
// short register queue between the front and back parts
// no dependencies
module hrlp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   // status and head entry
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/hrlp_back.sv @@
// back part: forms the end-of-line verdict and the result fields from a queued record
// depends on hrlp_pkg
module hrlp_back #(
   parameter int VERSION_BITS = 8
) (
   input  hrlp_pkg::front_rec_type  rec,
   input  logic [VERSION_BITS-1:0]  rec_major,
   input  logic [VERSION_BITS-1:0]  rec_minor,
   output logic [7:0]               byte_echo,
   output logic [2:0]               field_tag,
   output logic                     end_of_line,
   output logic                     line_valid,
   output logic [2:0]               method_code,
   output logic [7:0]               version_major,
   output logic [7:0]               version_minor
);

   logic [15:0] major_ext, minor_ext;
   logic [7:0]  major_sat, minor_sat;
   logic        valid;

   // clamp the counters to the eight-bit result range
   assign major_ext = 16'(rec_major);
   assign minor_ext = 16'(rec_minor);
   assign major_sat = (major_ext > 16'd255) ? 8'hFF : major_ext[7:0];
   assign minor_sat = (minor_ext > 16'd255) ? 8'hFF : minor_ext[7:0];

   // verdict: well-formed shape and a known method
   assign valid = rec.eol && rec.pre_valid && (rec.code != hrlp_pkg::CODE_NONE);

   // result fields
   always_comb begin
      byte_echo     = rec.line_byte;
      field_tag     = rec.tag;
      end_of_line   = rec.eol;
      line_valid    = valid;
      method_code   = valid ? rec.code[2:0] : 3'd0;
      version_major = 8'd0;
      version_minor = 8'd0;
      if (valid) begin
         version_major = rec.is_09 ? 8'd0 : major_sat;
         version_minor = rec.is_09 ? 8'd9 : minor_sat;
      end
   end

endmodule

@@ rtl/http_request_line_parser_core.sv @@
// top level of the http request line parser
// depends on hrlp_pkg, hrlp_front, hrlp_queue and hrlp_back
//
// Usage:
//   Input side is a queue write port: present one byte of the request line on
//   req_line_byte with req_line_end marking the last byte, and raise req_push;
//   the byte transfers at a clock edge where req_full is low. A zero byte also
//   closes the line. Results come out of a queue read port: while rsp_empty is
//   low the oldest result is on the rsp_ ports, and it transfers at an edge
//   where rsp_pop is high. Every input byte yields exactly one result.
//   The result that closes a line carries line_valid, method_code and the
//   version numbers; they read zero on all other results.
//   Throughput is one byte per cycle while req_full is low; the parse state
//   machine finishes each byte in the cycle it transfers. A result is held
//   in the queue behind older ones; up to QUEUE_DEPTH results wait when the
//   receiver stalls, and req_full rises once they are all taken up.
//   Synchronous reset returns the parser to the start of a line and empties
//   the result queue.
module http_request_line_parser_core #(
   parameter int VERSION_BITS = 8,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_line_byte,
   input  logic       req_line_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_byte_echo,
   output logic [2:0] rsp_field_tag,
   output logic       rsp_end_of_line,
   output logic       rsp_line_valid,
   output logic [2:0] rsp_method_code,
   output logic [7:0] rsp_version_major,
   output logic [7:0] rsp_version_minor
);

   localparam int REC_W = $bits(hrlp_pkg::front_rec_type);
   localparam int QW    = REC_W + 2 * VERSION_BITS;

   hrlp_pkg::front_rec_type front_rec, back_rec;
   logic [VERSION_BITS-1:0] front_major, front_minor, back_major, back_minor;
   logic [QW-1:0]           q_wr_data, q_rd_data;
   logic                    q_full, take;

   // input transfer
   assign take     = req_push && !q_full;
   assign req_full = q_full;

   // front part: parse and tag
   hrlp_front #(
      .VERSION_BITS(VERSION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .line_byte (req_line_byte),
      .line_end  (req_line_end),
      .rec       (front_rec),
      .rec_major (front_major),
      .rec_minor (front_minor)
   );

   // queue between front and back
   assign q_wr_data = {front_rec, front_major, front_minor};

   hrlp_queue #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (take),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (rsp_pop),
      .rd_data (q_rd_data),
      .empty   (rsp_empty)
   );

   assign back_rec   = hrlp_pkg::front_rec_type'(q_rd_data[QW-1 -: REC_W]);
   assign back_major = q_rd_data[2*VERSION_BITS-1 -: VERSION_BITS];
   assign back_minor = q_rd_data[VERSION_BITS-1:0];

   // back part: verdict and result fields
   hrlp_back #(
      .VERSION_BITS(VERSION_BITS)
   ) u_back (
      .rec           (back_rec),
      .rec_major     (back_major),
      .rec_minor     (back_minor),
      .byte_echo     (rsp_byte_echo),
      .field_tag     (rsp_field_tag),
      .end_of_line   (rsp_end_of_line),
      .line_valid    (rsp_line_valid),
      .method_code   (rsp_method_code),
      .version_major (rsp_version_major),
      .version_minor (rsp_version_minor)
   );

endmodule
